/* sv/ipv4_receive_header_filter_macros.svh */
`ifndef IPV4_RECEIVE_HEADER_FILTER_MACROS_SVH
`define IPV4_RECEIVE_HEADER_FILTER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define IPHF_ASSERT_NOW(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("IPv4 filter assertion failed");

// The condition must hold in the cycle after the trigger.
`define IPHF_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("IPv4 filter assertion failed");

`endif

/* sv/iphf_pkg.sv */
`timescale 1ns / 1ps

package iphf_pkg;

  localparam int MIN_HEADER_BYTES = 20;

  localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [15:0] MF_FLAG_MASK   = 16'h2000;
  localparam logic [15:0] OFFSET_MASK    = 16'h1FFF;
  localparam logic [31:0] ALL_ONES_ADDR  = 32'hFFFF_FFFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Byte offsets of the header fields.
  localparam logic [15:0] OFS_VERSION_IHL = 16'd0;
  localparam logic [15:0] OFS_LENGTH_HI   = 16'd2;
  localparam logic [15:0] OFS_LENGTH_LO   = 16'd3;
  localparam logic [15:0] OFS_FLAGS_HI    = 16'd6;
  localparam logic [15:0] OFS_FLAGS_LO    = 16'd7;
  localparam logic [15:0] OFS_PROTOCOL    = 16'd9;
  localparam logic [15:0] OFS_CHECKSUM_HI = 16'd10;
  localparam logic [15:0] OFS_CHECKSUM_LO = 16'd11;
  localparam logic [15:0] OFS_SOURCE0     = 16'd12;
  localparam logic [15:0] OFS_SOURCE3     = 16'd15;
  localparam logic [15:0] OFS_DEST0       = 16'd16;
  localparam logic [15:0] OFS_DEST3       = 16'd19;

  localparam logic [0:0] CFG_OUR_ADDRESS       = 1'd0;
  localparam logic [0:0] CFG_BROADCAST_ADDRESS = 1'd1;

  typedef enum logic [2:0] {
    VERDICT_DELIVER  = 3'd0,
    VERDICT_SHORT    = 3'd1,
    VERDICT_LENGTH   = 3'd2,
    VERDICT_CHECKSUM = 3'd3,
    VERDICT_NOT_OURS = 3'd4,
    VERDICT_FRAGMENT = 3'd5,
    VERDICT_PROTOCOL = 3'd6
  } verdict_e;

  typedef enum logic [1:0] {
    KIND_ICMP  = 2'd0,
    KIND_TCP   = 2'd1,
    KIND_UDP   = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  version_ihl;
    logic [15:0] length_field;
    logic [15:0] flags_offset;
    logic [7:0]  protocol_field;
    logic [15:0] stored_checksum;
    logic [31:0] source_field;
    logic [31:0] destination_field;
    logic [16:0] running_sum;
  } header_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  protocol;
    kind_e       transport_kind;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [5:0]  header_bytes;
    logic [15:0] total_length;
  } result_t;

endpackage

/* sv/iphf_verdict.sv */
`timescale 1ns / 1ps

module iphf_verdict (
  input  iphf_pkg::header_t hdr_i,
  input  logic [31:0]       our_address_i,
  input  logic [31:0]       broadcast_address_i,
  output iphf_pkg::result_t result_o
);

  logic [5:0]      hdr_len;
  logic [15:0]     calc_sum;
  logic            bad_length;
  logic            not_ours;
  logic            fragment;
  iphf_pkg::kind_e kind;

  always_comb begin
    hdr_len  = {hdr_i.version_ihl[3:0], 2'b00};
    calc_sum = ~hdr_i.running_sum[15:0];

    case (hdr_i.protocol_field)
      iphf_pkg::PROTO_ICMP: kind = iphf_pkg::KIND_ICMP;
      iphf_pkg::PROTO_TCP:  kind = iphf_pkg::KIND_TCP;
      iphf_pkg::PROTO_UDP:  kind = iphf_pkg::KIND_UDP;
      default:              kind = iphf_pkg::KIND_OTHER;
    endcase

    bad_length = (hdr_i.version_ihl[7:4] != iphf_pkg::IP_VERSION4) ||
                 (hdr_len < 6'(iphf_pkg::MIN_HEADER_BYTES)) ||
                 (hdr_i.length_field < {10'd0, hdr_len}) ||
                 (hdr_i.byte_count < hdr_i.length_field);
    not_ours   = (our_address_i != 32'd0) &&
                 (hdr_i.destination_field != our_address_i) &&
                 (hdr_i.destination_field != iphf_pkg::ALL_ONES_ADDR) &&
                 (hdr_i.destination_field != broadcast_address_i);
    fragment   = ((hdr_i.flags_offset & iphf_pkg::MF_FLAG_MASK) != 16'd0) ||
                 ((hdr_i.flags_offset & iphf_pkg::OFFSET_MASK) != 16'd0);

    if (hdr_i.byte_count < 16'(iphf_pkg::MIN_HEADER_BYTES)) begin
      result_o.verdict = iphf_pkg::VERDICT_SHORT;
    end else if (bad_length) begin
      result_o.verdict = iphf_pkg::VERDICT_LENGTH;
    end else if (calc_sum != hdr_i.stored_checksum) begin
      result_o.verdict = iphf_pkg::VERDICT_CHECKSUM;
    end else if (not_ours) begin
      result_o.verdict = iphf_pkg::VERDICT_NOT_OURS;
    end else if (fragment) begin
      result_o.verdict = iphf_pkg::VERDICT_FRAGMENT;
    end else if (kind == iphf_pkg::KIND_OTHER) begin
      result_o.verdict = iphf_pkg::VERDICT_PROTOCOL;
    end else begin
      result_o.verdict = iphf_pkg::VERDICT_DELIVER;
    end

    result_o.protocol            = hdr_i.protocol_field;
    result_o.transport_kind      = kind;
    result_o.source_address      = hdr_i.source_field;
    result_o.destination_address = hdr_i.destination_field;
    result_o.header_bytes        = hdr_len;
    result_o.total_length        = hdr_i.length_field;
  end

endmodule

/* sv/ipv4_receive_header_filter.sv */
`timescale 1ns / 1ps
// Receive-side IPv4 header filter.
// The input channel takes one packet byte per request in wire order, with
// last_byte_i set on the final byte. Every byte that is not the last produces
// no result. The final byte produces exactly one result request carrying the
// verdict and the captured header fields.
// Bytes are accepted one per cycle while in_stall_o is low. When the final
// byte is taken, its header is captured in the evaluation register, and the
// result is then registered into the output register behind out_valid_o.
// The configuration channel writes our_address (index 0) and
// broadcast_address (index 1); it is always ready and is meant to be used
// only while no packet is in flight.
// Reset clears both addresses, all packet state and both result stages.
// When the receiver holds out_stall_i, the result stays on the output, a
// second result can wait in the evaluation register, and in_stall_o is
// raised only once both are occupied and the output is still stalled.
// Non-final bytes could be absorbed in that case, but the input stalls on
// any byte to keep the handshake independent of the payload.

`include "ipv4_receive_header_filter_macros.svh"

module ipv4_receive_header_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [7:0]  protocol_o,
  output logic [1:0]  transport_kind_o,
  output logic [31:0] source_address_o,
  output logic [31:0] destination_address_o,
  output logic [5:0]  header_bytes_o,
  output logic [15:0] total_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] our_address_q;
  logic [31:0] broadcast_address_q;

  iphf_pkg::header_t hdr_q;
  iphf_pkg::header_t hdr_d;
  logic [7:0]        hold_q;
  logic [7:0]        hold_d;

  iphf_pkg::header_t eval_q;
  logic              eval_valid_q;
  logic              eval_valid_d;
  iphf_pkg::result_t eval_result;
  iphf_pkg::result_t result_q;
  logic              out_valid_q;

  logic        in_accept;
  logic        out_ready;
  logic        eval_ready;
  logic [15:0] pos;
  logic [5:0]  hdr_len;
  logic        in_hdr;
  logic [17:0] word_sum;
  logic [16:0] folded_sum;

  logic        last_accept;
  logic        count_open;
  logic [15:0] count_inc;
  logic        eval_stuck;
  logic        both_full;
  logic        deliver_out;
  logic        kind_known;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      our_address_q       <= 32'd0;
      broadcast_address_q <= 32'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        iphf_pkg::CFG_OUR_ADDRESS:       our_address_q       <= cfg_data_i;
        iphf_pkg::CFG_BROADCAST_ADDRESS: broadcast_address_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign eval_ready = !eval_valid_q || out_ready;
  assign in_stall_o = !eval_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Header field capture and running checksum for the current byte.
  always_comb begin
    pos   = hdr_q.byte_count;
    hdr_d = hdr_q;

    if (pos == iphf_pkg::OFS_VERSION_IHL) begin
      hdr_d.version_ihl = data_byte_i;
    end
    hdr_len = {hdr_d.version_ihl[3:0], 2'b00};

    if (pos == iphf_pkg::OFS_LENGTH_HI || pos == iphf_pkg::OFS_LENGTH_LO) begin
      hdr_d.length_field = {hdr_q.length_field[7:0], data_byte_i};
    end
    if (pos == iphf_pkg::OFS_FLAGS_HI || pos == iphf_pkg::OFS_FLAGS_LO) begin
      hdr_d.flags_offset = {hdr_q.flags_offset[7:0], data_byte_i};
    end
    if (pos == iphf_pkg::OFS_PROTOCOL) begin
      hdr_d.protocol_field = data_byte_i;
    end
    if (pos == iphf_pkg::OFS_CHECKSUM_HI || pos == iphf_pkg::OFS_CHECKSUM_LO) begin
      hdr_d.stored_checksum = {hdr_q.stored_checksum[7:0], data_byte_i};
    end
    if (pos >= iphf_pkg::OFS_SOURCE0 && pos <= iphf_pkg::OFS_SOURCE3) begin
      hdr_d.source_field = {hdr_q.source_field[23:0], data_byte_i};
    end
    if (pos >= iphf_pkg::OFS_DEST0 && pos <= iphf_pkg::OFS_DEST3) begin
      hdr_d.destination_field = {hdr_q.destination_field[23:0], data_byte_i};
    end

    in_hdr     = pos < {10'd0, hdr_len};
    word_sum   = {1'b0, hdr_q.running_sum} + {2'b00, hold_q, data_byte_i};
    folded_sum = {1'b0, word_sum[15:0]} + {15'd0, word_sum[17:16]};
    hold_d     = hold_q;
    if (in_hdr && !pos[0]) begin
      hold_d = data_byte_i;
    end else if (in_hdr && pos != iphf_pkg::OFS_CHECKSUM_LO) begin
      hdr_d.running_sum = folded_sum;
    end

    if (hdr_q.byte_count != iphf_pkg::BYTE_COUNT_MAX) begin
      hdr_d.byte_count = hdr_q.byte_count + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= '0;
      hold_q <= 8'd0;
    end else if (in_accept) begin
      if (last_byte_i) begin
        hdr_q  <= '0;
        hold_q <= 8'd0;
      end else begin
        hdr_q  <= hdr_d;
        hold_q <= hold_d;
      end
    end
  end

  always_comb begin
    eval_valid_d = eval_valid_q;
    if (in_accept && last_byte_i) begin
      eval_valid_d = 1'b1;
    end else if (out_ready) begin
      eval_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_valid_q <= 1'b0;
    end else begin
      eval_valid_q <= eval_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && last_byte_i) begin
      eval_q <= hdr_d;
    end
  end

  iphf_verdict u_verdict (
    .hdr_i               (eval_q),
    .our_address_i       (our_address_q),
    .broadcast_address_i (broadcast_address_q),
    .result_o            (eval_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= eval_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && eval_valid_q) begin
      result_q <= eval_result;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign verdict_o             = result_q.verdict;
  assign protocol_o            = result_q.protocol;
  assign transport_kind_o      = result_q.transport_kind;
  assign source_address_o      = result_q.source_address;
  assign destination_address_o = result_q.destination_address;
  assign header_bytes_o        = result_q.header_bytes;
  assign total_length_o        = result_q.total_length;

  assign last_accept = in_accept && last_byte_i;
  assign count_open  = in_accept && !last_byte_i &&
                       (hdr_q.byte_count != iphf_pkg::BYTE_COUNT_MAX);
  assign count_inc   = hdr_q.byte_count + 16'd1;
  assign eval_stuck  = eval_valid_q && !out_ready;
  assign both_full   = eval_valid_q && out_valid_q && out_stall_i;
  assign deliver_out = out_valid_o && (verdict_o == iphf_pkg::VERDICT_DELIVER);
  assign kind_known  = transport_kind_o != iphf_pkg::KIND_OTHER;

  `IPHF_ASSERT_NEXT(a_last_fills_eval, clk_i, rst_ni, last_accept, eval_valid_q)
  `IPHF_ASSERT_NEXT(a_last_clears_count, clk_i, rst_ni, last_accept, hdr_q.byte_count == 16'd0)
  `IPHF_ASSERT_NEXT(a_count_steps, clk_i, rst_ni, count_open, hdr_q.byte_count == $past(count_inc))
  `IPHF_ASSERT_NEXT(a_eval_holds, clk_i, rst_ni, eval_stuck, eval_valid_q && $stable(eval_q))
  `IPHF_ASSERT_NOW(a_full_stalls_input, clk_i, rst_ni, both_full, in_stall_o)
  `IPHF_ASSERT_NOW(a_deliver_known_kind, clk_i, rst_ni, deliver_out, kind_known)

endmodule

/* test/ipv4_verdict_monitor.sv */
`timescale 1ns / 1ps

module ipv4_verdict_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  verdict_i,
  input  logic [7:0]  protocol_i,
  input  logic [1:0]  transport_kind_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] destination_address_i,
  input  logic [5:0]  header_bytes_i,
  input  logic [15:0] total_length_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output logic [6:0]  verdicts_seen_o
);

  logic [31:0] local_addr;
  logic [31:0] bcast_addr;

  logic [15:0] seen_count;
  logic [7:0]  ver_ihl_q;
  logic [15:0] tot_len_q;
  logic [15:0] frag_q;
  logic [7:0]  proto_q;
  logic [15:0] csum_q;
  logic [31:0] src_q;
  logic [31:0] dst_q;
  logic [16:0] sum_q;
  logic [7:0]  hold_q;

  iphf_pkg::result_t pending_verdicts[$];

  task automatic clear_packet_state;
    seen_count = '0;
    ver_ihl_q  = '0;
    tot_len_q  = '0;
    frag_q     = '0;
    proto_q    = '0;
    csum_q     = '0;
    src_q      = '0;
    dst_q      = '0;
    sum_q      = '0;
    hold_q     = '0;
  endtask

  task automatic fold_word(input logic [15:0] word);
    logic [17:0] s;
    s = sum_q + word;
    sum_q = {1'b0, s[15:0]} + {15'd0, s[17:16]};
  endtask

  function automatic iphf_pkg::kind_e kind_of(input logic [7:0] proto);
    if (proto == iphf_pkg::PROTO_ICMP) return iphf_pkg::KIND_ICMP;
    if (proto == iphf_pkg::PROTO_TCP) return iphf_pkg::KIND_TCP;
    if (proto == iphf_pkg::PROTO_UDP) return iphf_pkg::KIND_UDP;
    return iphf_pkg::KIND_OTHER;
  endfunction

  task automatic absorb_packet_byte(input logic [7:0] b, input logic last);
    int pos;
    int hdr_len;
    logic [15:0] calc;
    iphf_pkg::result_t res;
    pos = seen_count;
    if (pos == iphf_pkg::OFS_VERSION_IHL) ver_ihl_q = b;
    hdr_len = ver_ihl_q[3:0] * 4;

    if (pos == iphf_pkg::OFS_LENGTH_HI || pos == iphf_pkg::OFS_LENGTH_LO) begin
      tot_len_q = {tot_len_q[7:0], b};
    end else if (pos == iphf_pkg::OFS_FLAGS_HI || pos == iphf_pkg::OFS_FLAGS_LO) begin
      frag_q = {frag_q[7:0], b};
    end else if (pos == iphf_pkg::OFS_PROTOCOL) begin
      proto_q = b;
    end else if (pos == iphf_pkg::OFS_CHECKSUM_HI || pos == iphf_pkg::OFS_CHECKSUM_LO) begin
      csum_q = {csum_q[7:0], b};
    end else if (pos >= iphf_pkg::OFS_SOURCE0 && pos <= iphf_pkg::OFS_SOURCE3) begin
      src_q = {src_q[23:0], b};
    end else if (pos >= iphf_pkg::OFS_DEST0 && pos <= iphf_pkg::OFS_DEST3) begin
      dst_q = {dst_q[23:0], b};
    end

    if (pos < hdr_len) begin
      if (pos % 2 == 0) hold_q = b;
      else if (pos != iphf_pkg::OFS_CHECKSUM_LO) fold_word({hold_q, b});
    end

    if (seen_count != iphf_pkg::BYTE_COUNT_MAX) seen_count++;
    if (!last) return;

    calc = ~sum_q[15:0];
    res.protocol            = proto_q;
    res.transport_kind      = kind_of(proto_q);
    res.source_address      = src_q;
    res.destination_address = dst_q;
    res.header_bytes        = 6'(hdr_len);
    res.total_length        = tot_len_q;
    if (seen_count < iphf_pkg::MIN_HEADER_BYTES) begin
      res.verdict = iphf_pkg::VERDICT_SHORT;
    end else if (ver_ihl_q[7:4] != iphf_pkg::IP_VERSION4 ||
                 hdr_len < iphf_pkg::MIN_HEADER_BYTES ||
                 tot_len_q < hdr_len || seen_count < tot_len_q) begin
      res.verdict = iphf_pkg::VERDICT_LENGTH;
    end else if (calc != csum_q) begin
      res.verdict = iphf_pkg::VERDICT_CHECKSUM;
    end else if (local_addr != '0 && dst_q != local_addr &&
                 dst_q != iphf_pkg::ALL_ONES_ADDR && dst_q != bcast_addr) begin
      res.verdict = iphf_pkg::VERDICT_NOT_OURS;
    end else if ((frag_q & (iphf_pkg::MF_FLAG_MASK | iphf_pkg::OFFSET_MASK)) != '0) begin
      res.verdict = iphf_pkg::VERDICT_FRAGMENT;
    end else if (res.transport_kind == iphf_pkg::KIND_OTHER) begin
      res.verdict = iphf_pkg::VERDICT_PROTOCOL;
    end else begin
      res.verdict = iphf_pkg::VERDICT_DELIVER;
    end
    pending_verdicts.push_back(res);
    clear_packet_state();
  endtask

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic compare_result;
    iphf_pkg::result_t want;
    int bad;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: result with no packet pending, actual verdict %0d", $time, verdict_i);
      fail_count_o++;
      return;
    end
    want = pending_verdicts.pop_front();
    bad = field_differs("verdict", want.verdict, verdict_i);
    bad += field_differs("protocol", want.protocol, protocol_i);
    bad += field_differs("transport_kind", want.transport_kind, transport_kind_i);
    bad += field_differs("source_address", want.source_address, source_address_i);
    bad += field_differs("destination_address", want.destination_address,
                         destination_address_i);
    bad += field_differs("header_bytes", want.header_bytes, header_bytes_i);
    bad += field_differs("total_length", want.total_length, total_length_i);
    if (bad != 0) fail_count_o++;
    checked_o++;
    verdicts_seen_o[want.verdict] = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr = '0;
      bcast_addr = '0;
      clear_packet_state();
      pending_verdicts.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      verdicts_seen_o = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == iphf_pkg::CFG_OUR_ADDRESS) local_addr = cfg_data_i;
        else if (cfg_index_i == iphf_pkg::CFG_BROADCAST_ADDRESS) bcast_addr = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) absorb_packet_byte(data_byte_i, last_byte_i);
      pending_o = pending_verdicts.size();
    end
  end

endmodule

/* test/tb_ipv4_receive_header_filter.sv */
`timescale 1ns / 1ps

module tb_ipv4_receive_header_filter;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  verdict_o;
  logic [7:0]  protocol_o;
  logic [1:0]  transport_kind_o;
  logic [31:0] source_address_o;
  logic [31:0] destination_address_o;
  logic [5:0]  header_bytes_o;
  logic [15:0] total_length_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int          fail_count;
  int          pending_count;
  int          checked_count;
  logic [6:0]  verdicts_seen;

  logic [7:0]  frame[$];
  logic [31:0] our_addr;
  logic [31:0] bcast_addr;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  bit          hold_go = 1'b0;
  int          bytes_sent = 0;

  ipv4_receive_header_filter dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .data_byte_i           (data_byte_i),
    .last_byte_i           (last_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .verdict_o             (verdict_o),
    .protocol_o            (protocol_o),
    .transport_kind_o      (transport_kind_o),
    .source_address_o      (source_address_o),
    .destination_address_o (destination_address_o),
    .header_bytes_o        (header_bytes_o),
    .total_length_o        (total_length_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  ipv4_verdict_monitor verdict_monitor (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .data_byte_i           (data_byte_i),
    .last_byte_i           (last_byte_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .verdict_i             (verdict_o),
    .protocol_i            (protocol_o),
    .transport_kind_i      (transport_kind_o),
    .source_address_i      (source_address_o),
    .destination_address_i (destination_address_o),
    .header_bytes_i        (header_bytes_o),
    .total_length_i        (total_length_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_i           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .fail_count_o          (fail_count),
    .pending_o             (pending_count),
    .checked_o             (checked_count),
    .verdicts_seen_o       (verdicts_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver waits a drawn number of cycles on each result, or holds off
  // for a long stretch when asked to.
  initial begin
    int wait_left;
    int hold_left;
    bit took;
    out_stall_i = 1'b0;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      took = out_valid_o && !out_stall_i;
      @(negedge clk_i);
      if (hold_go) begin
        hold_left = 300;
        hold_go = 1'b0;
      end
      if (took) wait_left = recv_quiet ? 0 : $urandom_range(0, 14);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (out_valid_o && wait_left > 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame;
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic wait_idle;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_addresses(input logic [31:0] ours, input logic [31:0] bcast);
    write_reg(iphf_pkg::CFG_OUR_ADDRESS, ours);
    write_reg(iphf_pkg::CFG_BROADCAST_ADDRESS, bcast);
    our_addr = ours;
    bcast_addr = bcast;
  endtask

  // Builds a packet with a correct header checksum unless one is corrupted on
  // purpose. Fewer bytes than the header holds gives a truncated packet.
  task automatic build_frame(input logic [3:0] version, input logic [3:0] ihl,
                             input logic [15:0] len_field, input int actual,
                             input logic [15:0] flags, input logic [7:0] proto,
                             input logic [31:0] dst, input bit bad_sum);
    logic [7:0] hdr[0:59];
    logic [17:0] s;
    logic [16:0] acc;
    logic [15:0] sum;
    for (int i = 0; i < 60; i++) hdr[i] = 8'($urandom);
    hdr[0] = {version, ihl};
    {hdr[2], hdr[3]} = len_field;
    {hdr[6], hdr[7]} = flags;
    hdr[9] = proto;
    {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
    acc = '0;
    for (int i = 0; i < ihl * 4; i += 2) begin
      if (i != iphf_pkg::OFS_CHECKSUM_HI) begin
        s = acc + {hdr[i], hdr[i + 1]};
        acc = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      end
    end
    sum = ~acc[15:0];
    if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    {hdr[10], hdr[11]} = sum;
    frame.delete();
    for (int i = 0; i < actual; i++) frame.push_back(i < 60 ? hdr[i] : 8'($urandom));
  endtask

  function automatic logic [31:0] pick_destination;
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return our_addr;
    if (r < 5) return bcast_addr;
    if (r == 5) return iphf_pkg::ALL_ONES_ADDR;
    if (r == 6) return '0;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_address;
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r == 2) return iphf_pkg::ALL_ONES_ADDR;
    return $urandom;
  endfunction

  task automatic send_random_packet;
    int r;
    int ihl;
    int actual;
    logic [3:0] version;
    logic [15:0] len;
    logic [15:0] flags;
    logic [7:0] proto;
    bit bad_sum;
    send_quiet = $urandom_range(0, 3) == 0;
    recv_quiet = $urandom_range(0, 3) == 0;
    ihl = $urandom_range(0, 2) != 0 ? 5 : $urandom_range(5, 15);
    actual = ihl * 4 + $urandom_range(0, 12);
    len = 16'(actual);
    version = iphf_pkg::IP_VERSION4;
    flags = {2'($urandom), 14'd0};
    case ($urandom_range(0, 2))
      0: proto = iphf_pkg::PROTO_ICMP;
      1: proto = iphf_pkg::PROTO_TCP;
      default: proto = iphf_pkg::PROTO_UDP;
    endcase
    bad_sum = 1'b0;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      actual = $urandom_range(1, 19);
    end else if (r >= 87) begin
      do proto = 8'($urandom);
      while (proto == iphf_pkg::PROTO_ICMP || proto == iphf_pkg::PROTO_TCP ||
             proto == iphf_pkg::PROTO_UDP);
    end else if (r >= 82) begin
      flags = flags | ($urandom_range(0, 1) ? iphf_pkg::MF_FLAG_MASK : 16'd0) |
              (16'($urandom) & iphf_pkg::OFFSET_MASK);
      if ((flags & (iphf_pkg::MF_FLAG_MASK | iphf_pkg::OFFSET_MASK)) == 16'd0) begin
        flags = flags | iphf_pkg::MF_FLAG_MASK;
      end
    end else if (r >= 77) begin
      len = 16'(actual + $urandom_range(1, 40));
    end else if (r >= 72) begin
      len = 16'($urandom_range(0, ihl * 4 - 1));
    end else if (r >= 68) begin
      ihl = $urandom_range(0, 4);
    end else if (r >= 63) begin
      do version = 4'($urandom);
      while (version == iphf_pkg::IP_VERSION4);
    end else if (r >= 55) begin
      bad_sum = 1'b1;
    end
    build_frame(version, 4'(ihl), len, actual, flags, proto, pick_destination(), bad_sum);
    if (r >= 98) begin
      frame.delete();
      repeat ($urandom_range(1, 70)) frame.push_back(8'($urandom));
    end
    send_frame();
  endtask

  initial begin
    int start;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = iphf_pkg::CFG_OUR_ADDRESS;
    cfg_data_i  = '0;
    our_addr    = '0;
    bcast_addr  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unconfigured address: every destination is accepted.
    frame = '{8'h00};
    send_frame();
    frame.delete();
    repeat (19) frame.push_back(8'hFF);
    send_frame();
    frame.delete();
    repeat (20) frame.push_back(8'h00);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_ICMP, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd15, 16'd72, 72, 16'h4000,
                iphf_pkg::PROTO_TCP, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd28, 28, 16'd0,
                iphf_pkg::PROTO_UDP, 32'd0, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                8'h00, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'hC000,
                8'hFF, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_TCP, $urandom, 1'b1);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, iphf_pkg::MF_FLAG_MASK,
                iphf_pkg::PROTO_UDP, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, iphf_pkg::OFFSET_MASK,
                iphf_pkg::PROTO_UDP, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd19, 20, 16'd0,
                iphf_pkg::PROTO_ICMP, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd21, 20, 16'd0,
                iphf_pkg::PROTO_ICMP, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 28, 16'd0,
                iphf_pkg::PROTO_ICMP, $urandom, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd4, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_ICMP, $urandom, 1'b0);
    send_frame();
    build_frame(4'd6, 4'd5, 16'd20, 20, 16'd0, iphf_pkg::PROTO_ICMP, $urandom, 1'b0);
    send_frame();

    wait_idle();
    set_addresses({1'b1, 31'($urandom)}, $urandom);
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_TCP, our_addr, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_UDP, bcast_addr, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_ICMP, iphf_pkg::ALL_ONES_ADDR, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_ICMP, our_addr ^ 32'h1, 1'b0);
    send_frame();

    // A zero broadcast register matches a zero destination.
    wait_idle();
    set_addresses(iphf_pkg::ALL_ONES_ADDR, 32'd0);
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_UDP, 32'd0, 1'b0);
    send_frame();
    build_frame(iphf_pkg::IP_VERSION4, 4'd5, 16'd20, 20, 16'd0,
                iphf_pkg::PROTO_UDP, 32'h0A00_0001, 1'b0);
    send_frame();

    // The receiver holds off while short packets keep arriving.
    wait_idle();
    hold_go = 1'b1;
    send_quiet = 1'b1;
    repeat (6) begin
      frame.delete();
      repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
      send_frame();
    end
    send_quiet = 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      set_addresses(pick_address(), pick_address());
      start = bytes_sent;
      while (bytes_sent - start < 500) send_random_packet();
    end
    while (checked_count < 60) send_random_packet();
    wait_idle();

    $display("Sent %0d bytes and checked %0d verdicts over several address settings.",
             bytes_sent, checked_count);
    $display("Verdict classes seen, one bit per class from deliver upward: %b",
             verdicts_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/iphf_pkg.sv
sv/iphf_verdict.sv
sv/ipv4_receive_header_filter.sv
test/ipv4_verdict_monitor.sv
test/tb_ipv4_receive_header_filter.sv
